// File: sv/size_class_block_allocator_macros.svh
// Assertion helpers for the size-class block allocator.
// Both forms are clocked on aclk and ignore cycles in reset.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define SCBA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("allocator check failed");
`define SCBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("allocator check failed");
`else
`define SCBA_ASSERT_NOW(label, ante, cons)
`define SCBA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: sv/scba_pkg.sv
package scba_pkg;

    localparam int NUM_CLASSES   = 9;
    localparam int MIN_BLOCK_LOG = 8;
    localparam int PAGE_LOG      = 20;
    localparam int MAX_PAGES     = 4;

    // Field widths of the transaction payloads.
    localparam int SIZE_W   = 32;
    localparam int CLASS_W  = 4;
    localparam int FPAGE_W  = 2;
    localparam int FBLOCK_W = 12;
    localparam int OFFSET_W = 20;
    localparam int STATUS_W = 2;

    localparam int BLK_W   = (PAGE_LOG > MIN_BLOCK_LOG) ? (PAGE_LOG - MIN_BLOCK_LOG) : 1;
    localparam int PAGE_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int ENTRY_W = PAGE_W + BLK_W;
    localparam int CIDX_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int PCNT_W  = $clog2(MAX_PAGES + 1);
    localparam int LOW_W   = BLK_W + 1;
    localparam int CAP_MAX = MAX_PAGES << BLK_W;
    localparam int TOP_W   = $clog2(CAP_MAX + 1);

    // Entries one class can hold on its stack.
    function automatic int class_cap(int c);
        if (MIN_BLOCK_LOG + c > PAGE_LOG) begin
            return 0;
        end
        return MAX_PAGES << (PAGE_LOG - MIN_BLOCK_LOG - c);
    endfunction

    function automatic int stack_total();
        int sum;
        sum = 0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            sum += class_cap(c);
        end
        return sum;
    endfunction

    localparam int MEM_DEPTH = (stack_total() > 2) ? stack_total() : 2;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    typedef logic [ADDR_W-1:0] base_tbl_t [NUM_CLASSES];

    // Each class owns a contiguous region of the stack memory.
    function automatic base_tbl_t make_base();
        base_tbl_t tbl;
        int        sum;
        sum = 0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            tbl[c] = ADDR_W'(sum);
            sum += class_cap(c);
        end
        return tbl;
    endfunction

    localparam base_tbl_t CLASS_BASE = make_base();

    function automatic logic class_fits(logic [CLASS_W-1:0] c);
        return (MIN_BLOCK_LOG + int'(c)) <= PAGE_LOG;
    endfunction

    // log2 of blocks per page; only meaningful when the class fits a page.
    function automatic logic [4:0] blocks_log(logic [CLASS_W-1:0] c);
        return 5'(PAGE_LOG - MIN_BLOCK_LOG - int'(c));
    endfunction

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_LARGE     = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_FREE_ERR  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEC,
        S_EXEC
    } state_t;

    // Decision taken in the decode cycle and carried out in the execute cycle.
    typedef struct packed {
        status_t             status;
        logic [CLASS_W-1:0]  cls;
        logic [CIDX_W-1:0]   ci;
        logic [PAGE_W-1:0]   page;
        logic [BLK_W-1:0]    block;
        logic                from_mem;
        logic                upd;
        logic [TOP_W-1:0]    top;
        logic [PCNT_W-1:0]   pages;
        logic [LOW_W-1:0]    low;
        logic                wr;
        logic [ADDR_W-1:0]   addr;
        logic [ENTRY_W-1:0]  wdata;
    } plan_t;

endpackage

// File: sv/size_class_block_allocator.sv
// Channel   Dir  tdata fields (low bit up)                           tuser
// s_        in   req_size, free_class, free_page, free_block, pad    func
// m_        out  size_class, page, block, byte_offset, pad           status
//
// Every transaction passes through a decode state that picks the class, checks
// the per-class counters and issues the stack memory read, and an execute state that
// uses the read data, writes back and commits. The next request is taken at the commit.
// Reset clears the per-class counters, state and output valid, not the stack memory.
// A result waiting on m_tready holds the block in its execute cycle with s_tready
// low; no further request is taken until the output register frees up.
`include "size_class_block_allocator_macros.svh"

module size_class_block_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // req_size [31:0], free_class [35:32], free_page [37:36],
    // free_block [49:38], zero [55:50]
    input  logic [55:0] s_tdata,
    // func [0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // size_class [3:0], page [5:4], block [17:6], byte_offset [37:18],
    // zero [39:38]
    output logic [39:0] m_tdata,
    // status [1:0]
    output logic [1:0]  m_tuser
);

    // Request fields captured when a transaction is accepted.
    logic                            func_reg;
    logic [scba_pkg::SIZE_W-1:0]     size_reg;
    logic [scba_pkg::CLASS_W-1:0]    fclass_reg;
    logic [scba_pkg::FPAGE_W-1:0]    fpage_reg;
    logic [scba_pkg::FBLOCK_W-1:0]   fblock_reg;

    // Per-class state. The stack holds top_reg entries. Entries below
    // low_reg still hold the blocks of the most recently opened page in
    // order, so a fresh page never has to be written out to memory.
    logic [scba_pkg::TOP_W-1:0]  top_reg   [scba_pkg::NUM_CLASSES];
    logic [scba_pkg::PCNT_W-1:0] pages_reg [scba_pkg::NUM_CLASSES];
    logic [scba_pkg::LOW_W-1:0]  low_reg   [scba_pkg::NUM_CLASSES];

    scba_pkg::state_t state_reg, state_next;
    scba_pkg::plan_t  plan_reg, plan_next;

    logic commit;
    logic accept;

    // Stack memory: one read and one write port, registered read data.
    logic [scba_pkg::ENTRY_W-1:0] stack_mem [scba_pkg::MEM_DEPTH];
    logic [scba_pkg::ENTRY_W-1:0] mem_rdata_reg;
    logic                         mem_rd_en;
    logic                         mem_wr_en;

    // Output register.
    logic                            m_tvalid_reg;
    scba_pkg::status_t               out_status_reg;
    logic [scba_pkg::CLASS_W-1:0]    out_class_reg;
    logic [scba_pkg::FPAGE_W-1:0]    out_page_reg;
    logic [scba_pkg::FBLOCK_W-1:0]   out_block_reg;
    logic [scba_pkg::OFFSET_W-1:0]   out_offset_reg;

    // Execute-cycle result values.
    logic [scba_pkg::PAGE_W-1:0]     exec_page;
    logic [scba_pkg::BLK_W-1:0]      exec_block;
    logic [scba_pkg::OFFSET_W-1:0]   exec_offset;

    // ---------------------------------------------------------------
    // Control state machine.
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= scba_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        commit     = 1'b0;
        s_tready   = 1'b0;
        unique case (state_reg)
            scba_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = scba_pkg::S_DEC;
                end
            end
            scba_pkg::S_DEC: begin
                state_next = scba_pkg::S_EXEC;
            end
            scba_pkg::S_EXEC: begin
                // The result can leave once the output register frees up.
                commit   = !m_tvalid_reg || m_tready;
                s_tready = commit;
                if (commit) begin
                    state_next = s_tvalid ? scba_pkg::S_DEC : scba_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = scba_pkg::S_IDLE;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg   <= s_tuser[0];
            size_reg   <= s_tdata[31:0];
            fclass_reg <= s_tdata[35:32];
            fpage_reg  <= s_tdata[37:36];
            fblock_reg <= s_tdata[49:38];
        end
    end

    // ---------------------------------------------------------------
    // Decode: choose the class, check counters, plan the stack access.
    // ---------------------------------------------------------------
    logic [scba_pkg::CLASS_W-1:0] size_cls;
    logic                         too_large;
    logic [scba_pkg::CLASS_W-1:0] cls;
    logic                         cls_ok;
    logic [scba_pkg::CIDX_W-1:0]  ci;
    logic [scba_pkg::TOP_W-1:0]   cur_top;
    logic [scba_pkg::PCNT_W-1:0]  cur_pages;
    logic [scba_pkg::LOW_W-1:0]   cur_low;
    logic                         fits;
    logic [4:0]                   blog;
    logic [scba_pkg::LOW_W-1:0]   nblk;
    logic [scba_pkg::TOP_W-1:0]   cap_now;
    logic [scba_pkg::TOP_W-1:0]   pop_idx;

    always_comb begin
        // The class is the count of class thresholds the size exceeds.
        size_cls  = '0;
        for (int k = 0; k < scba_pkg::NUM_CLASSES - 1; k++) begin
            if (size_reg > (32'd1 << (scba_pkg::MIN_BLOCK_LOG + k))) begin
                size_cls = scba_pkg::CLASS_W'(k + 1);
            end
        end
        too_large = size_reg >
                    (32'd1 << (scba_pkg::MIN_BLOCK_LOG + scba_pkg::NUM_CLASSES - 1));

        cls    = func_reg ? fclass_reg : size_cls;
        cls_ok = !func_reg || (32'(fclass_reg) < scba_pkg::NUM_CLASSES);
        ci     = cls_ok ? scba_pkg::CIDX_W'(cls) : '0;

        cur_top   = top_reg[ci];
        cur_pages = pages_reg[ci];
        cur_low   = low_reg[ci];
        fits      = scba_pkg::class_fits(cls);
        blog      = scba_pkg::blocks_log(cls);
        nblk      = scba_pkg::LOW_W'(1) << blog;
        cap_now   = scba_pkg::TOP_W'(cur_pages) << blog;
        pop_idx   = cur_top - scba_pkg::TOP_W'(1);

        plan_next          = '0;
        plan_next.status   = scba_pkg::ST_OK;
        plan_next.cls      = cls;
        plan_next.ci       = ci;
        plan_next.top      = cur_top;
        plan_next.pages    = cur_pages;
        plan_next.low      = cur_low;

        if (!func_reg) begin
            if (too_large) begin
                plan_next.status = scba_pkg::ST_LARGE;
                plan_next.cls    = '0;
            end else if (cur_top == '0) begin
                if (!fits || 32'(cur_pages) >= scba_pkg::MAX_PAGES) begin
                    plan_next.status = scba_pkg::ST_EXHAUSTED;
                end else begin
                    // Open a page; its last block is handed out at once.
                    plan_next.upd   = 1'b1;
                    plan_next.page  = scba_pkg::PAGE_W'(cur_pages);
                    plan_next.block = scba_pkg::BLK_W'(nblk - scba_pkg::LOW_W'(1));
                    plan_next.top   = scba_pkg::TOP_W'(nblk) - scba_pkg::TOP_W'(1);
                    plan_next.pages = cur_pages + scba_pkg::PCNT_W'(1);
                    plan_next.low   = nblk - scba_pkg::LOW_W'(1);
                end
            end else begin
                plan_next.upd = 1'b1;
                plan_next.top = pop_idx;
                if (32'(pop_idx) < 32'(cur_low)) begin
                    // Still an untouched block of the newest page.
                    plan_next.page  = scba_pkg::PAGE_W'(cur_pages - scba_pkg::PCNT_W'(1));
                    plan_next.block = scba_pkg::BLK_W'(pop_idx);
                    plan_next.low   = scba_pkg::LOW_W'(pop_idx);
                end else begin
                    plan_next.from_mem = 1'b1;
                    plan_next.addr     = scba_pkg::CLASS_BASE[ci] +
                                         scba_pkg::ADDR_W'(pop_idx);
                end
            end
        end else begin
            if (!cls_ok || !fits || 32'(fpage_reg) >= 32'(cur_pages) ||
                32'(fblock_reg) >= 32'(nblk) || cur_top >= cap_now) begin
                plan_next.status = scba_pkg::ST_FREE_ERR;
                plan_next.cls    = '0;
            end else begin
                plan_next.upd   = 1'b1;
                plan_next.wr    = 1'b1;
                plan_next.page  = scba_pkg::PAGE_W'(fpage_reg);
                plan_next.block = scba_pkg::BLK_W'(fblock_reg);
                plan_next.top   = cur_top + scba_pkg::TOP_W'(1);
                plan_next.addr  = scba_pkg::CLASS_BASE[ci] + scba_pkg::ADDR_W'(cur_top);
                plan_next.wdata = {scba_pkg::PAGE_W'(fpage_reg),
                                   scba_pkg::BLK_W'(fblock_reg)};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == scba_pkg::S_DEC) begin
            plan_reg <= plan_next;
        end
    end

    // ---------------------------------------------------------------
    // Stack memory.
    // ---------------------------------------------------------------
    assign mem_rd_en = (state_reg == scba_pkg::S_DEC) && plan_next.from_mem;
    assign mem_wr_en = commit && plan_reg.wr;

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            stack_mem[plan_reg.addr] <= plan_reg.wdata;
        end
        if (mem_rd_en) begin
            mem_rdata_reg <= stack_mem[plan_next.addr];
        end
    end

    // ---------------------------------------------------------------
    // Execute: commit counters and load the output register.
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < scba_pkg::NUM_CLASSES; c++) begin
                top_reg[c]   <= '0;
                pages_reg[c] <= '0;
                low_reg[c]   <= '0;
            end
        end else if (commit && plan_reg.upd) begin
            top_reg[plan_reg.ci]   <= plan_reg.top;
            pages_reg[plan_reg.ci] <= plan_reg.pages;
            low_reg[plan_reg.ci]   <= plan_reg.low;
        end
    end

    always_comb begin
        exec_page  = plan_reg.from_mem ? mem_rdata_reg[scba_pkg::ENTRY_W-1:scba_pkg::BLK_W]
                                       : plan_reg.page;
        exec_block = plan_reg.from_mem ? mem_rdata_reg[scba_pkg::BLK_W-1:0] : plan_reg.block;
        exec_offset = '0;
        if (plan_reg.status == scba_pkg::ST_OK) begin
            exec_offset = scba_pkg::OFFSET_W'(32'(exec_block) <<
                          (scba_pkg::MIN_BLOCK_LOG + int'(plan_reg.cls)));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            out_status_reg <= plan_reg.status;
            out_class_reg  <= plan_reg.cls;
            out_page_reg   <= scba_pkg::FPAGE_W'(exec_page);
            out_block_reg  <= scba_pkg::FBLOCK_W'(exec_block);
            out_offset_reg <= exec_offset;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_offset_reg, out_block_reg, out_page_reg, out_class_reg};

    // ---------------------------------------------------------------
    // Checks.
    // ---------------------------------------------------------------
    `SCBA_ASSERT_NEXT(a_accept_then_decode, accept, state_reg == scba_pkg::S_DEC)
    `SCBA_ASSERT_NEXT(a_read_then_execute, mem_rd_en, state_reg == scba_pkg::S_EXEC && plan_reg.from_mem)
    `SCBA_ASSERT_NOW(a_error_no_offset, m_tvalid && m_tuser != scba_pkg::ST_OK, m_tdata[37:18] == 20'd0)

endmodule

// File: test/tb_size_class_block_allocator.sv
module tb_size_class_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    // Function codes carried in s_tuser.
    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 3;
    // Random requests after the directed opening rows.
    localparam int RANDOM_ITEMS = 625;
    // The last stretch of the run goes without any idling on either side.
    localparam int QUIET_TAIL   = 100;
    // Random request index at which the receiver backs the block up.
    localparam int CHOKE_AT     = 250;
    localparam int HOLD_CYCLES  = 200;
    // Spare cycles to catch any stray response after the last one.
    localparam int DRAIN_CYCLES = 12;
    localparam longint WATCHDOG_NS = 64'd5_000_000;

    // Fields of one allocator request, as packed onto s_tdata and s_tuser.
    typedef struct {
        logic                          func;
        logic [scba_pkg::SIZE_W-1:0]   size;
        logic [scba_pkg::CLASS_W-1:0]  fclass;
        logic [scba_pkg::FPAGE_W-1:0]  fpage;
        logic [scba_pkg::FBLOCK_W-1:0] fblock;
    } alloc_req_t;

    // Fields of one allocator response, as unpacked from m_tdata and m_tuser.
    typedef struct {
        scba_pkg::status_t             status;
        logic [scba_pkg::CLASS_W-1:0]  cls;
        logic [scba_pkg::FPAGE_W-1:0]  page;
        logic [scba_pkg::FBLOCK_W-1:0] block;
        logic [scba_pkg::OFFSET_W-1:0] offset;
    } alloc_rsp_t;

    // One (page, block) pair as held on a class's free stack.
    typedef struct packed {
        logic [scba_pkg::FPAGE_W-1:0]  page;
        logic [scba_pkg::FBLOCK_W-1:0] block;
    } block_slot_t;

    // A block handed out by the allocator and not yet returned.
    typedef struct {
        logic [scba_pkg::CLASS_W-1:0]  cls;
        logic [scba_pkg::FPAGE_W-1:0]  page;
        logic [scba_pkg::FBLOCK_W-1:0] block;
    } held_block_t;

    // A directed row: the request, and optionally a response typed in by hand.
    typedef struct {
        alloc_req_t req;
        bit         typed;
        alloc_rsp_t rsp;
    } plan_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    // req_size [31:0], free_class [35:32], free_page [37:36],
    // free_block [49:38], zero [55:50]
    logic [55:0]         s_tdata;
    // func [0]
    logic [0:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    // size_class [3:0], page [5:4], block [17:6], byte_offset [37:18],
    // zero [39:38]
    logic [39:0]         m_tdata;
    // status [1:0]
    logic [1:0]          m_tuser;

    // Shadow of the allocator's bookkeeping, advanced once per accepted request.
    int unsigned         pages_opened [scba_pkg::NUM_CLASSES];
    int unsigned         stack_depth  [scba_pkg::NUM_CLASSES];
    block_slot_t         free_stack   [scba_pkg::NUM_CLASSES][scba_pkg::CAP_MAX];

    // Responses owed by the block, oldest first.
    alloc_rsp_t          pending_grants[$];
    // Blocks currently out on loan, used to build well-formed frees.
    held_block_t         held_blocks[$];
    plan_row_t           opening_rows[$];

    bit                  idle_on;
    bit                  choke_req;
    int                  mismatches = 0;
    int unsigned         status_seen [4] = '{default: 0};

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    size_class_block_allocator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Number of blocks one page holds for class c; zero when a single block
    // of that class would not fit in a page.
    function automatic int unsigned blocks_in_page(int unsigned c);
        if (scba_pkg::MIN_BLOCK_LOG + c > scba_pkg::PAGE_LOG) begin
            return 0;
        end
        return 1 << (scba_pkg::PAGE_LOG - scba_pkg::MIN_BLOCK_LOG - c);
    endfunction

    // Applies one accepted request to the shadow state and returns the
    // response that the allocator owes for it.
    function automatic alloc_rsp_t predict_grant(alloc_req_t req);
        alloc_rsp_t  rsp;
        int unsigned c;
        int unsigned lg;
        int unsigned nblk;
        int unsigned top;
        block_slot_t slot;
        held_block_t loan;

        rsp.status = scba_pkg::ST_OK;
        rsp.cls    = '0;
        rsp.page   = '0;
        rsp.block  = '0;
        rsp.offset = '0;

        if (req.func == FN_ALLOC) begin
            // Below the smallest block, zero included, everything lands in
            // class 0; above the largest class nothing is pooled.
            if (64'(req.size) < (64'd1 << scba_pkg::MIN_BLOCK_LOG)) begin
                c = 0;
            end else if (64'(req.size) >
                         (64'd1 << (scba_pkg::MIN_BLOCK_LOG + scba_pkg::NUM_CLASSES - 1))) begin
                rsp.status = scba_pkg::ST_LARGE;
                return rsp;
            end else begin
                lg = 0;
                while ((64'd1 << lg) < 64'(req.size)) begin
                    lg++;
                end
                c = lg - scba_pkg::MIN_BLOCK_LOG;
            end
            nblk    = blocks_in_page(c);
            rsp.cls = scba_pkg::CLASS_W'(c);
            if (stack_depth[c] == 0) begin
                // An empty stack opens a fresh page, pushing blocks 0 up to
                // n-1 so that the highest block comes out first.
                if (nblk == 0 || pages_opened[c] >= scba_pkg::MAX_PAGES) begin
                    rsp.status = scba_pkg::ST_EXHAUSTED;
                    return rsp;
                end
                for (int unsigned i = 0; i < nblk; i++) begin
                    free_stack[c][i] = '{page: scba_pkg::FPAGE_W'(pages_opened[c]),
                                         block: scba_pkg::FBLOCK_W'(i)};
                end
                stack_depth[c]  = nblk;
                pages_opened[c] = pages_opened[c] + 1;
            end
            stack_depth[c] = stack_depth[c] - 1;
            slot       = free_stack[c][stack_depth[c]];
            rsp.page   = slot.page;
            rsp.block  = slot.block;
            rsp.offset = scba_pkg::OFFSET_W'(64'(slot.block) << (scba_pkg::MIN_BLOCK_LOG + c));
            loan.cls   = rsp.cls;
            loan.page  = rsp.page;
            loan.block = rsp.block;
            held_blocks = {held_blocks, loan};
            return rsp;
        end

        c = req.fclass;
        if (c >= scba_pkg::NUM_CLASSES) begin
            rsp.status = scba_pkg::ST_FREE_ERR;
            return rsp;
        end
        nblk = blocks_in_page(c);
        top  = stack_depth[c];
        // Reject an unknown page, an out-of-range block, or a push onto a
        // stack that already holds every block of its open pages.
        if (nblk == 0 || req.fpage >= pages_opened[c] || req.fblock >= nblk ||
            top >= pages_opened[c] * nblk) begin
            rsp.status = scba_pkg::ST_FREE_ERR;
            return rsp;
        end
        free_stack[c][top] = '{page: req.fpage, block: req.fblock};
        stack_depth[c]     = top + 1;
        rsp.cls    = req.fclass;
        rsp.page   = req.fpage;
        rsp.block  = req.fblock;
        rsp.offset = scba_pkg::OFFSET_W'(64'(req.fblock) << (scba_pkg::MIN_BLOCK_LOG + c));
        return rsp;
    endfunction

    function automatic alloc_req_t alloc_req(logic [scba_pkg::SIZE_W-1:0] size);
        alloc_req_t req;
        req.func   = FN_ALLOC;
        req.size   = size;
        req.fclass = '0;
        req.fpage  = '0;
        req.fblock = '0;
        return req;
    endfunction

    function automatic alloc_req_t free_req(int unsigned c, int unsigned pg, int unsigned blk);
        alloc_req_t req;
        req.func   = FN_FREE;
        req.size   = '0;
        req.fclass = scba_pkg::CLASS_W'(c);
        req.fpage  = scba_pkg::FPAGE_W'(pg);
        req.fblock = scba_pkg::FBLOCK_W'(blk);
        return req;
    endfunction

    function automatic alloc_rsp_t grant(scba_pkg::status_t st, int unsigned c,
                                         int unsigned pg, int unsigned blk,
                                         int unsigned off);
        alloc_rsp_t rsp;
        rsp.status = st;
        rsp.cls    = scba_pkg::CLASS_W'(c);
        rsp.page   = scba_pkg::FPAGE_W'(pg);
        rsp.block  = scba_pkg::FBLOCK_W'(blk);
        rsp.offset = scba_pkg::OFFSET_W'(off);
        return rsp;
    endfunction

    function automatic plan_row_t checked(alloc_req_t req, alloc_rsp_t rsp);
        plan_row_t row;
        row.req   = req;
        row.typed = 1'b1;
        row.rsp   = rsp;
        return row;
    endfunction

    function automatic plan_row_t predicted(alloc_req_t req);
        plan_row_t row;
        row.req   = req;
        row.typed = 1'b0;
        row.rsp   = grant(scba_pkg::ST_OK, 0, 0, 0, 0);
        return row;
    endfunction

    // Appends one row to the directed opening table.
    function automatic void queue_row(plan_row_t row);
        opening_rows = {opening_rows, row};
    endfunction

    // Builds one random request. Most traffic is well formed: allocations
    // of sizes spread over the classes (weighted toward the big ones so that
    // their few pages run out), and frees of blocks that are really on loan.
    // A small share is noise: raw 32-bit sizes and frees with arbitrary fields.
    function automatic alloc_req_t random_request(bit filling);
        held_block_t victim;
        int unsigned roll;
        int unsigned c;
        int unsigned pick;
        int unsigned hi;
        int unsigned lo;
        logic [scba_pkg::SIZE_W-1:0] size;

        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            return alloc_req($urandom());
        end
        if (roll < 8) begin
            return free_req($urandom_range(0, 15), $urandom_range(0, 3),
                            $urandom_range(0, 4095));
        end

        if (held_blocks.size() != 0 && $urandom_range(0, 99) < (filling ? 15 : 80)) begin
            if ($urandom_range(0, 9) == 0) begin
                // A stale free: plausible fields, but the block may already
                // sit on the stack, so it can hit the full-stack check.
                c = $urandom_range(0, scba_pkg::NUM_CLASSES - 1);
                return free_req(c, $urandom_range(0, scba_pkg::MAX_PAGES - 1),
                                $urandom_range(0, blocks_in_page(c) - 1));
            end
            pick   = $urandom_range(0, held_blocks.size() - 1);
            victim = held_blocks[pick];
            held_blocks.delete(pick);
            return free_req(victim.cls, victim.page, victim.block);
        end

        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            c = scba_pkg::NUM_CLASSES - 1;
        end else if (roll < 75) begin
            c = scba_pkg::NUM_CLASSES - 2;
        end else begin
            c = $urandom_range(0, scba_pkg::NUM_CLASSES - 3);
        end
        hi = 1 << (scba_pkg::MIN_BLOCK_LOG + c);
        lo = (c == 0) ? 0 : (hi >> 1) + 1;
        // Class edges are where the rounding can go wrong, so hit them often.
        case ($urandom_range(0, 3))
            0: begin
                size = hi;
            end
            1: begin
                size = lo;
            end
            default: begin
                size = $urandom_range(lo, hi);
            end
        endcase
        return alloc_req(size);
    endfunction

    // Offers one request on the input channel and, once it is accepted,
    // records the response it is owed. Inputs move only at falling edges;
    // the handshake is sampled at the rising edge.
    task automatic offer(plan_row_t row);
        alloc_rsp_t rsp;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {6'b0, row.req.fblock, row.req.fpage, row.req.fclass, row.req.size};
        s_tuser  = row.req.func;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        // The shadow state advances on every accepted request, even when the
        // expected response for a directed row was typed in by hand.
        rsp = predict_grant(row.req);
        pending_grants = {pending_grants, (row.typed ? row.rsp : rsp)};
        @(negedge aclk);
    endtask

    task automatic check_field(string name, logic [39:0] want, logic [39:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // Response checker. Every accepted response transaction is compared,
    // field by field, against the oldest outstanding expectation.
    always @(posedge aclk) begin
        alloc_rsp_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_grants.size() == 0) begin
                mismatches++;
                $error("response transaction arrived with no request outstanding");
            end else begin
                want = pending_grants.pop_front();
                check_field("status", 40'(want.status), 40'(m_tuser));
                check_field("size_class", 40'(want.cls), 40'(m_tdata[3:0]));
                check_field("page", 40'(want.page), 40'(m_tdata[5:4]));
                check_field("block", 40'(want.block), 40'(m_tdata[17:6]));
                check_field("byte_offset", 40'(want.offset), 40'(m_tdata[37:18]));
                status_seen[want.status]++;
            end
        end
    end

    // Receiver side. It stalls in random bursts while idling is enabled and,
    // once on request, holds off for a long fixed stretch so that the block
    // fills its pipeline and has to drop s_tready.
    initial begin
        int unsigned gap;
        bit          choke_done;
        m_tready   = 1'b0;
        choke_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (choke_req && !choke_done) begin
                choke_done = 1'b1;
                m_tready   = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_tready = 1'b1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                gap      = $urandom_range(1, 17);
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Stimulus: a directed opening from the reset state, then random traffic
    // in segments that either fill the pools or drain them back.
    initial begin
        int unsigned sent;
        int unsigned seg_len;
        bit          filling;
        int          seg;

        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        idle_on    = 1'b1;
        choke_req  = 1'b0;
        for (int c = 0; c < scba_pkg::NUM_CLASSES; c++) begin
            pages_opened[c] = 0;
            stack_depth[c]  = 0;
        end

        // The first allocation of a class opens page 0 and returns its
        // highest block, so these responses can be written down directly.
        queue_row(checked(alloc_req(0), grant(scba_pkg::ST_OK, 0, 0, 4095, 'hFFF00)));
        queue_row(predicted(alloc_req(256)));
        queue_row(predicted(alloc_req(257)));
        queue_row(checked(alloc_req(65536), grant(scba_pkg::ST_OK, 8, 0, 15, 'hF0000)));
        // One byte past the largest class, and the largest size there is.
        queue_row(checked(alloc_req(65537), grant(scba_pkg::ST_LARGE, 0, 0, 0, 0)));
        queue_row(checked(alloc_req('1), grant(scba_pkg::ST_LARGE, 0, 0, 0, 0)));
        // Free errors: class out of range, page never opened, block beyond
        // the page.
        queue_row(checked(free_req(9, 0, 0), grant(scba_pkg::ST_FREE_ERR, 0, 0, 0, 0)));
        queue_row(checked(free_req(15, 3, 4095), grant(scba_pkg::ST_FREE_ERR, 0, 0, 0, 0)));
        queue_row(checked(free_req(8, 1, 0), grant(scba_pkg::ST_FREE_ERR, 0, 0, 0, 0)));
        queue_row(checked(free_req(8, 0, 16), grant(scba_pkg::ST_FREE_ERR, 0, 0, 0, 0)));
        // Returning the class 8 block fills the stack again; a second
        // return of the same block is a double free and must be refused.
        queue_row(checked(free_req(8, 0, 15), grant(scba_pkg::ST_OK, 8, 0, 15, 'hF0000)));
        queue_row(checked(free_req(8, 0, 15), grant(scba_pkg::ST_FREE_ERR, 0, 0, 0, 0)));
        queue_row(predicted(free_req(0, 0, 4095)));
        queue_row(predicted(alloc_req(255)));
        queue_row(predicted(free_req(0, 3, 4095)));
        queue_row(predicted(alloc_req(32768)));
        queue_row(predicted(alloc_req(32769)));
        queue_row(predicted(alloc_req(1)));
        queue_row(predicted(alloc_req(4096)));
        queue_row(predicted(alloc_req(4097)));
        queue_row(predicted(free_req(1, 0, 2047)));
        queue_row(predicted(free_req(2, 0, 0)));
        queue_row(checked(alloc_req('h8000_0000), grant(scba_pkg::ST_LARGE, 0, 0, 0, 0)));
        queue_row(predicted(free_req(8, 2, 4095)));

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (opening_rows[i]) begin
            offer(opening_rows[i]);
        end

        // Fill segments lean on allocation so the two largest classes run
        // out of pages; drain segments mostly hand blocks back.
        sent = 0;
        seg  = 0;
        while (sent < RANDOM_ITEMS) begin
            seg_len = $urandom_range(30, 90);
            filling = (seg == 0) || ($urandom_range(0, 9) < 6);
            idle_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
                if (sent >= RANDOM_ITEMS - QUIET_TAIL) begin
                    idle_on = 1'b0;
                end
                if (sent == CHOKE_AT) begin
                    choke_req = 1'b1;
                end
                offer(predicted(random_request(filling)));
                sent++;
            end
            seg++;
        end
        s_tvalid = 1'b0;

        while (pending_grants.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d requests: %0d ok, %0d too large, %0d out of pages, %0d bad frees.",
                 opening_rows.size() + sent, status_seen[scba_pkg::ST_OK],
                 status_seen[scba_pkg::ST_LARGE], status_seen[scba_pkg::ST_EXHAUSTED],
                 status_seen[scba_pkg::ST_FREE_ERR]);
        $display("Idle bursts ran on both channels, and one %0d-cycle receiver hold-off.",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("tb_size_class_block_allocator OK");
        end else begin
            $display("tb_size_class_block_allocator NOT OK");
        end
        $finish;
    end

    // Watchdog against a hung handshake on either channel.
    initial begin
        #(WATCHDOG_NS);
        $display("Timed out with %0d responses outstanding.", pending_grants.size());
        $display("tb_size_class_block_allocator NOT OK");
        $finish;
    end

endmodule
